[hdl/ccs_pkg.sv]
// Package for the case-folding substring search block.
// Holds field widths, register indexes, the configuration struct and byte helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

   localparam int BYTE_W   = 8;
   localparam int POS_W    = 32;
   localparam int LEN_W    = 5;
   localparam int WORD_W   = 64;
   localparam int PAT_W    = 2 * WORD_W;
   localparam int CSR_IDX_W = 8;

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW    = 8'd0,
      CSR_PATTERN_HIGH   = 8'd1,
      CSR_PATTERN_LENGTH = 8'd2,
      CSR_CASE_FOLD      = 8'd3
   } csr_index_type;

   // Configuration as seen by the window cells
   typedef struct packed {
      logic [PAT_W-1:0] pattern;    // byte 0 in bits 7..0
      logic [LEN_W-1:0] used_len;   // clamped to 1..PATTERN_MAX
      logic             case_fold;
   } cfg_type;

   // Fold a-z to A-Z when folding is on
   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c,
                                              input logic en);
      logic [BYTE_W-1:0] r;
      r = c;
      if (en && c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   // Pick one pattern byte
   function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PAT_W-1:0] pat,
                                                      input logic [3:0] idx);
      return pat[{idx, 3'b000} +: BYTE_W];
   endfunction

endpackage

`default_nettype wire

[hdl/ccs_if.sv]
// Channel interfaces of the case-folding substring search block.
// Request, response and register write channels; depends on ccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ccs_req_if;
   logic                        valid;
   logic                        ready;
   logic [ccs_pkg::BYTE_W-1:0]  text_byte;
   logic                        first_of_text;
   logic                        last_of_text;
   logic [ccs_pkg::POS_W-1:0]   start_position;

   modport source (output valid, text_byte, first_of_text, last_of_text,
                   start_position, input ready);
   modport sink   (input valid, text_byte, first_of_text, last_of_text,
                   start_position, output ready);
endinterface

interface ccs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [ccs_pkg::POS_W-1:0]   match_start;
   logic [ccs_pkg::POS_W-1:0]   match_end;

   modport source (output valid, found, match_start, match_end, input ready);
   modport sink   (input valid, found, match_start, match_end, output ready);
endinterface

interface ccs_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ccs_pkg::CSR_IDX_W-1:0] index;
   logic [ccs_pkg::WORD_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/ccs_csr_regs.sv]
// Configuration registers of the case-folding substring search block.
// Takes register writes and presents the clamped configuration; uses ccs_pkg, ccs_if.
`timescale 1ns / 1ps
`default_nettype none

module ccs_csr_regs #(
   parameter int PATTERN_MAX = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ccs_csr_if.sink          csr,
   output ccs_pkg::cfg_type cfg
);

   localparam logic [ccs_pkg::LEN_W-1:0] MAX_LEN = ccs_pkg::LEN_W'(PATTERN_MAX);

   logic [ccs_pkg::WORD_W-1:0] pat_low_ff;
   logic [ccs_pkg::WORD_W-1:0] pat_high_ff;
   logic [ccs_pkg::LEN_W-1:0]  length_ff;
   logic                       fold_ff;
   logic [ccs_pkg::LEN_W-1:0]  used_len;

   // Always take writes
   assign csr.ready = 1'b1;

   // Write the addressed register, drop writes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         length_ff   <= ccs_pkg::LEN_W'(1);
         fold_ff     <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            ccs_pkg::CSR_PATTERN_LOW: begin
               pat_low_ff <= csr.data;
            end
            ccs_pkg::CSR_PATTERN_HIGH: begin
               pat_high_ff <= csr.data;
            end
            ccs_pkg::CSR_PATTERN_LENGTH: begin
               length_ff <= csr.data[ccs_pkg::LEN_W-1:0];
            end
            ccs_pkg::CSR_CASE_FOLD: begin
               fold_ff <= csr.data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp the length: zero counts as one, cap at the window depth
   always_comb begin
      used_len = length_ff;
      if (length_ff == '0) begin
         used_len = ccs_pkg::LEN_W'(1);
      end else if (length_ff > MAX_LEN) begin
         used_len = MAX_LEN;
      end
   end

   assign cfg.pattern   = {pat_high_ff, pat_low_ff};
   assign cfg.used_len  = used_len;
   assign cfg.case_fold = fold_ff;

endmodule

`default_nettype wire

[hdl/ccs_cell.sv]
// One window cell of the case-folding substring search block.
// Holds one text byte, passes it on, and compares its incoming byte with its pattern byte.
// Uses ccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccs_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                       clock,
   input  wire logic                       shift,
   input  wire logic [ccs_pkg::BYTE_W-1:0] byte_in,
   output logic [ccs_pkg::BYTE_W-1:0]      byte_out,
   input  wire ccs_pkg::cfg_type           cfg,
   output logic                            match
);

   localparam logic [ccs_pkg::LEN_W-1:0] CELL_IDX = ccs_pkg::LEN_W'(INDEX);

   logic [ccs_pkg::BYTE_W-1:0] byte_ff;
   logic [ccs_pkg::LEN_W-1:0]  pat_idx;
   logic [ccs_pkg::BYTE_W-1:0] pat_byte;

   // Advance the window on every accepted item
   always_ff @(posedge clock) begin
      if (shift) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

   // The cell k from the newest byte lines up with pattern byte len-1-k
   assign pat_idx  = cfg.used_len - CELL_IDX - ccs_pkg::LEN_W'(1);
   assign pat_byte = ccs_pkg::pattern_byte(cfg.pattern, pat_idx[3:0]);

   // Cells past the pattern length always agree
   assign match = (CELL_IDX >= cfg.used_len) ||
                  (ccs_pkg::fold(byte_in, cfg.case_fold) ==
                   ccs_pkg::fold(pat_byte, cfg.case_fold));

endmodule

`default_nettype wire

[hdl/case_folding_substring_search_top.sv]
// Top level of the case-folding substring search block.
// Instantiates the register block and the row of window cells; uses ccs_pkg, ccs_if.
`timescale 1ns / 1ps
`default_nettype none

// Searches a byte stream for the first occurrence of a pattern of 1 to PATTERN_MAX
// bytes, optionally folding a-z to A-Z on both sides. One text byte is taken per
// clock; each byte shifts into a row of PATTERN_MAX cells, and all cells compare
// against the pattern in the same cycle, so the throughput is one item per cycle
// and the result appears on the response channel in the cycle after the byte that
// caused it. A single response register sits on the output: a new byte is taken
// whenever that register is empty or is being drained in the same cycle. At most
// one response per text: found=1 with the start and end positions on the first
// match, or found=0 on the last byte if nothing matched. No clearing pass after
// reset. Registers must be written only while idle; the block does not enforce it.
module case_folding_substring_search_top #(
   parameter int PATTERN_MAX = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   ccs_req_if.sink   req_chan,
   ccs_rsp_if.source rsp_chan,
   ccs_csr_if.sink   csr_chan
);

   localparam logic [ccs_pkg::POS_W-1:0] SEEN_MAX = '1;

   ccs_pkg::cfg_type cfg;

   logic [ccs_pkg::BYTE_W-1:0] window [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]     cell_match;

   logic                       accept;
   logic                       hit;
   logic                       emit;
   logic                       reported_eff;

   logic [ccs_pkg::POS_W-1:0]  seen_ff;
   logic [ccs_pkg::POS_W-1:0]  seen_in;
   logic [ccs_pkg::POS_W-1:0]  last_pos_ff;
   logic [ccs_pkg::POS_W-1:0]  last_pos_in;
   logic                       reported_ff;
   logic                       reported_in;

   logic                       rsp_valid_ff;
   logic                       found_ff;
   logic                       found_in;
   logic [ccs_pkg::POS_W-1:0]  start_ff;
   logic [ccs_pkg::POS_W-1:0]  start_in;
   logic [ccs_pkg::POS_W-1:0]  end_ff;
   logic [ccs_pkg::POS_W-1:0]  end_in;

   ccs_csr_regs #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   // Row of window cells, newest byte in cell 0
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [ccs_pkg::BYTE_W-1:0] byte_in;
      if (k == 0) begin : g_head
         assign byte_in = req_chan.text_byte;
      end else begin : g_link
         assign byte_in = window[k-1];
      end
      ccs_cell #(
         .INDEX (k)
      ) u_cell (
         .clock    (clock),
         .shift    (accept),
         .byte_in  (byte_in),
         .byte_out (window[k]),
         .cfg      (cfg),
         .match    (cell_match[k])
      );
   end

   // Take a new item when the response register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Byte count and position of the newest byte after this item
   always_comb begin
      if (req_chan.first_of_text) begin
         seen_in     = ccs_pkg::POS_W'(1);
         last_pos_in = req_chan.start_position;
      end else if (seen_ff == SEEN_MAX) begin
         seen_in     = seen_ff;
         last_pos_in = last_pos_ff;
      end else begin
         seen_in     = seen_ff + ccs_pkg::POS_W'(1);
         last_pos_in = last_pos_ff + ccs_pkg::POS_W'(1);
      end
   end

   // Decide whether this item gives a response
   always_comb begin
      hit          = (&cell_match) && (seen_in >= ccs_pkg::POS_W'(cfg.used_len));
      reported_eff = req_chan.first_of_text ? 1'b0 : reported_ff;
      emit         = !reported_eff && (hit || req_chan.last_of_text);
      reported_in  = reported_eff || emit;
      found_in     = hit;
      if (hit) begin
         end_in   = last_pos_in;
         start_in = last_pos_in - (ccs_pkg::POS_W'(cfg.used_len) - ccs_pkg::POS_W'(1));
      end else begin
         end_in   = '0;
         start_in = '0;
      end
   end

   // Text tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         last_pos_ff <= '1;
         reported_ff <= 1'b0;
      end else if (accept) begin
         seen_ff     <= seen_in;
         last_pos_ff <= last_pos_in;
         reported_ff <= reported_in;
      end
   end

   // Response register: load on a result, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         found_ff <= found_in;
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = found_ff;
   assign rsp_chan.match_start = start_ff;
   assign rsp_chan.match_end   = end_ff;

`ifndef SYNTHESIS
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> start_ff == '0 && end_ff == '0)
      else $error("miss response carries nonzero positions");

   a_span_len : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && found_ff |->
         (end_ff - start_ff) == (ccs_pkg::POS_W'(cfg.used_len) - ccs_pkg::POS_W'(1)))
      else $error("match span does not equal pattern length");

   a_done_set : assert property (@(posedge clock) disable iff (reset)
      accept && emit |=> reported_ff)
      else $error("done flag not set after a response");

   a_done_needs_byte : assert property (@(posedge clock) disable iff (reset)
      seen_ff == '0 |-> !reported_ff && !rsp_valid_ff)
      else $error("done flag or response without any byte taken");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the case-folding substring search block.
// Drives text bytes and register writes, predicts each search result and checks it.
// Depends on ccs_pkg, the ccs channel interfaces and case_folding_substring_search_top.
`timescale 1ns / 1ps

module tb_top;

   localparam int          PATTERN_MAX   = 16;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_BYTES   = 228;
   localparam int          STALL_PCT     = 35;
   localparam logic [7:0]  LOWER_A       = 8'h61;
   localparam logic [7:0]  LOWER_Z       = 8'h7A;
   localparam logic [7:0]  CASE_BIT      = 8'h20;

   typedef struct packed {
      logic [7:0]  text_byte;
      logic        first_of_text;
      logic        last_of_text;
      logic [31:0] start_position;
   } text_item_type;

   typedef struct packed {
      logic        found;
      logic [31:0] match_start;
      logic [31:0] match_end;
   } match_result_type;

   typedef struct packed {
      ccs_pkg::csr_index_type idx;
      logic [63:0]            data;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset;

   ccs_req_if req_chan ();
   ccs_rsp_if rsp_chan ();
   ccs_csr_if csr_chan ();

   case_folding_substring_search_top #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // Stimulus and expectation stores
   text_item_type    text_items_q[$];
   reg_write_type    reg_writes_q[$];
   match_result_type pending_matches[$];

   // Shadow copy of the block's registers and search state
   logic [63:0] pat_lo;
   logic [63:0] pat_hi;
   logic [4:0]  pat_len_reg;
   logic        fold_on;
   logic [7:0]  recent_bytes[PATTERN_MAX];
   logic [31:0] seen_count;
   logic [31:0] text_base;
   logic        reported;

   bit no_stall = 1'b0;
   int unsigned error_count   = 0;
   int unsigned bytes_sent    = 0;
   int unsigned results_seen  = 0;
   int unsigned matches_seen  = 0;
   int unsigned writes_done   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decide whether a side moves this cycle
   function automatic bit take_turn();
      return no_stall || ($urandom_range(99) >= STALL_PCT);
   endfunction

   // Pattern length as the block uses it, clamped to 1..PATTERN_MAX
   function automatic int unsigned pattern_span();
      if (pat_len_reg == 0) return 1;
      if (pat_len_reg > PATTERN_MAX) return PATTERN_MAX;
      return 32'(pat_len_reg);
   endfunction

   function automatic logic [7:0] pattern_at(int unsigned i);
      logic [127:0] pat;
      pat = {pat_hi, pat_lo};
      return pat[i*8 +: 8];
   endfunction

   function automatic logic [7:0] upcase(logic [7:0] c);
      if (fold_on && c >= LOWER_A && c <= LOWER_Z) return c - CASE_BIT;
      return c;
   endfunction

   function automatic logic [7:0] flip_case(logic [7:0] c);
      logic [7:0] low;
      low = c | CASE_BIT;
      if (low >= LOWER_A && low <= LOWER_Z) return c ^ CASE_BIT;
      return c;
   endfunction

   // Shift one text byte into the shadow window and queue the result it causes
   function automatic void search_next_byte(text_item_type it);
      int unsigned      len;
      bit               hit;
      logic [31:0]      first_pos;
      match_result_type res;
      len = pattern_span();
      if (it.first_of_text) begin
         foreach (recent_bytes[k]) recent_bytes[k] = 8'h00;
         seen_count = 32'd0;
         text_base  = it.start_position;
         reported   = 1'b0;
      end
      for (int k = PATTERN_MAX - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = it.text_byte;
      if (seen_count != 32'hFFFF_FFFF) seen_count++;
      if (reported) return;
      hit = (seen_count >= len);
      for (int unsigned i = 0; hit && i < len; i++) begin
         if (upcase(recent_bytes[len-1-i]) != upcase(pattern_at(i))) hit = 1'b0;
      end
      if (hit) begin
         first_pos       = text_base + (seen_count - len);
         res.found       = 1'b1;
         res.match_start = first_pos;
         res.match_end   = first_pos + (len - 1);
         reported        = 1'b1;
         pending_matches.push_back(res);
      end else if (it.last_of_text) begin
         res      = '0;
         reported = 1'b1;
         pending_matches.push_back(res);
      end
   endfunction

   // Text driver: account for the accepted item, then offer the next one
   always @(posedge clock) begin
      text_item_type it;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            it.text_byte      = req_chan.text_byte;
            it.first_of_text  = req_chan.first_of_text;
            it.last_of_text   = req_chan.last_of_text;
            it.start_position = req_chan.start_position;
            search_next_byte(it);
            bytes_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (text_items_q.size() != 0 && take_turn()) begin
               it = text_items_q.pop_front();
               req_chan.valid          <= 1'b1;
               req_chan.text_byte      <= it.text_byte;
               req_chan.first_of_text  <= it.first_of_text;
               req_chan.last_of_text   <= it.last_of_text;
               req_chan.start_position <= it.start_position;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Register write driver: update the shadow registers on acceptance
   always @(posedge clock) begin
      reg_write_type wr;
      if (reset) begin
         csr_chan.valid <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               ccs_pkg::CSR_PATTERN_LOW:    pat_lo      = csr_chan.data;
               ccs_pkg::CSR_PATTERN_HIGH:   pat_hi      = csr_chan.data;
               ccs_pkg::CSR_PATTERN_LENGTH: pat_len_reg = csr_chan.data[4:0];
               ccs_pkg::CSR_CASE_FOLD:      fold_on     = csr_chan.data[0];
               default: ;
            endcase
            writes_done++;
         end
         if (!csr_chan.valid || csr_chan.ready) begin
            if (reg_writes_q.size() != 0) begin
               wr = reg_writes_q.pop_front();
               csr_chan.valid <= 1'b1;
               csr_chan.index <= wr.idx;
               csr_chan.data  <= wr.data;
            end else begin
               csr_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      match_result_type exp_res;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (rsp_chan.found) matches_seen++;
            if (pending_matches.size() == 0) begin
               $error("unexpected result: found=%0d start=%h end=%h",
                      rsp_chan.found, rsp_chan.match_start, rsp_chan.match_end);
               error_count++;
            end else begin
               exp_res = pending_matches.pop_front();
               if (rsp_chan.found !== exp_res.found) begin
                  $error("found mismatch: expected %0d, got %0d",
                         exp_res.found, rsp_chan.found);
                  error_count++;
               end
               if (rsp_chan.match_start !== exp_res.match_start) begin
                  $error("match_start mismatch: expected %h, got %h",
                         exp_res.match_start, rsp_chan.match_start);
                  error_count++;
               end
               if (rsp_chan.match_end !== exp_res.match_end) begin
                  $error("match_end mismatch: expected %h, got %h",
                         exp_res.match_end, rsp_chan.match_end);
                  error_count++;
               end
            end
         end
         rsp_chan.ready <= take_turn();
      end
   end

   task automatic push_text(logic [7:0] b, logic first, logic last, logic [31:0] pos);
      text_item_type it;
      it.text_byte      = b;
      it.first_of_text  = first;
      it.last_of_text   = last;
      it.start_position = pos;
      text_items_q.push_back(it);
   endtask

   task automatic push_write(ccs_pkg::csr_index_type idx, logic [63:0] data);
      reg_write_type wr;
      wr.idx  = idx;
      wr.data = data;
      reg_writes_q.push_back(wr);
   endtask

   // Hold until every item is taken and every result has come, then let the block settle
   task automatic wait_idle();
      do @(negedge clock);
      while (text_items_q.size() != 0 || req_chan.valid || pending_matches.size() != 0 ||
             reg_writes_q.size() != 0 || csr_chan.valid);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_start();
      int unsigned roll;
      roll = $urandom_range(9);
      if (roll < 2) return 32'hFFFF_FFFF - $urandom_range(40);
      if (roll < 3) return $urandom_range(8);
      return $urandom;
   endfunction

   // Text filler: mostly pattern bytes, some letters, some arbitrary bytes
   function automatic logic [7:0] text_filler(int unsigned span);
      int unsigned roll;
      logic [7:0]  b;
      roll = $urandom_range(99);
      if (roll < 60) begin
         b = pattern_at($urandom_range(span - 1));
         return $urandom_range(1) ? flip_case(b) : b;
      end
      if (roll < 70) begin
         b = LOWER_A + 8'($urandom_range(25));
         return $urandom_range(1) ? b - CASE_BIT : b;
      end
      return 8'($urandom_range(255));
   endfunction

   // New random register settings; the phase number steers the extremes
   task automatic queue_random_config(int unsigned phase);
      logic [127:0] pat;
      logic [4:0]   len;
      for (int b = 0; b < PATTERN_MAX; b++) begin
         case ($urandom_range(5))
            0:       pat[b*8 +: 8] = 8'($urandom_range(255));
            1:       pat[b*8 +: 8] = 8'hFF;
            2:       pat[b*8 +: 8] = LOWER_Z;
            default: pat[b*8 +: 8] = LOWER_A + 8'($urandom_range(2));
         endcase
      end
      if (phase == 0) pat = '0;
      if (phase == 1) pat = '1;
      case (phase)
         0:       len = 5'd0;
         1:       len = 5'd16;
         2:       len = 5'd31;
         3:       len = 5'd1;
         4:       len = 5'd17;
         default: len = 5'($urandom_range(2, 15));
      endcase
      push_write(ccs_pkg::CSR_PATTERN_LOW,    pat[63:0]);
      push_write(ccs_pkg::CSR_PATTERN_HIGH,   pat[127:64]);
      push_write(ccs_pkg::CSR_PATTERN_LENGTH, ({$urandom, $urandom} & ~64'h1F) | len);
      if (phase < 6)
         push_write(ccs_pkg::CSR_CASE_FOLD, ({$urandom, $urandom} & ~64'h1) | (phase % 2));
      else
         push_write(ccs_pkg::CSR_CASE_FOLD, {$urandom, $urandom});
   endtask

   // Random texts: mostly well-formed, often with a planted pattern, the rest broken framing
   task automatic queue_random_texts(int unsigned quota);
      int unsigned span, len, at, kind, queued;
      logic [7:0]  body[$];
      logic [7:0]  b;
      queued = 0;
      span   = pattern_span();
      while (queued < quota) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 24);
         body.delete();
         for (int unsigned k = 0; k < len; k++) body.push_back(text_filler(span));
         if ($urandom_range(99) < 55 && len >= span) begin
            at = $urandom_range(0, len - span);
            for (int unsigned k = 0; k < span; k++) begin
               b = pattern_at(k);
               body[at + k] = $urandom_range(1) ? flip_case(b) : b;
            end
         end
         kind = $urandom_range(99);
         for (int unsigned k = 0; k < len; k++) begin
            push_text(body[k], (k == 0) && !(kind >= 80 && kind < 90),
                      (k == len - 1) && (kind < 90), pick_start());
         end
         queued += len;
      end
   endtask

   initial begin
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.text_byte      = 8'h00;
      req_chan.first_of_text  = 1'b0;
      req_chan.last_of_text   = 1'b0;
      req_chan.start_position = 32'd0;
      rsp_chan.ready          = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.index          = ccs_pkg::CSR_PATTERN_LOW;
      csr_chan.data           = 64'd0;
      pat_lo      = 64'd0;
      pat_hi      = 64'd0;
      pat_len_reg = 5'd1;
      fold_on     = 1'b0;
      foreach (recent_bytes[k]) recent_bytes[k] = 8'h00;
      seen_count  = 32'd0;
      text_base   = 32'd0;
      reported    = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings, no first byte yet: the text starts at position zero
      push_text(8'h41, 1'b0, 1'b0, 32'hFFFF_FFFF);
      push_text(8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF);
      push_text(8'h00, 1'b0, 1'b1, 32'd0);
      wait_idle();

      // Folded three-letter pattern whose match wraps the position counter
      push_write(ccs_pkg::CSR_PATTERN_LOW,    64'h0000_0000_0063_6261);
      push_write(ccs_pkg::CSR_PATTERN_HIGH,   64'hFFFF_FFFF_FFFF_FFFF);
      push_write(ccs_pkg::CSR_PATTERN_LENGTH, 64'd3);
      push_write(ccs_pkg::CSR_CASE_FOLD,      64'd1);
      wait_idle();
      push_text(8'h78, 1'b1, 1'b0, 32'hFFFF_FFFE);
      push_text(8'h41, 1'b0, 1'b0, 32'd0);
      push_text(8'h62, 1'b0, 1'b0, 32'd0);
      push_text(8'h43, 1'b0, 1'b1, 32'd0);
      push_text(8'h61, 1'b0, 1'b0, 32'd0);
      push_text(8'h71, 1'b1, 1'b1, 32'd5);
      wait_idle();

      // Full-width pattern with letter boundaries, length above the cap, match on the last byte
      push_write(ccs_pkg::CSR_PATTERN_LOW,    64'hFF00_5B40_7B60_7A61);
      push_write(ccs_pkg::CSR_PATTERN_HIGH,   64'h6120_FE01_7F80_5A41);
      push_write(ccs_pkg::CSR_PATTERN_LENGTH, 64'd17);
      wait_idle();
      push_text(8'h41, 1'b1, 1'b0, 32'd100);
      push_text(8'h5A, 1'b0, 1'b0, 32'd0);
      push_text(8'h60, 1'b0, 1'b0, 32'd0);
      push_text(8'h7B, 1'b0, 1'b0, 32'd0);
      push_text(8'h40, 1'b0, 1'b0, 32'd0);
      push_text(8'h5B, 1'b0, 1'b0, 32'd0);
      push_text(8'h00, 1'b0, 1'b0, 32'd0);
      push_text(8'hFF, 1'b0, 1'b0, 32'd0);
      push_text(8'h61, 1'b0, 1'b0, 32'd0);
      push_text(8'h7A, 1'b0, 1'b0, 32'd0);
      push_text(8'h80, 1'b0, 1'b0, 32'd0);
      push_text(8'h7F, 1'b0, 1'b0, 32'd0);
      push_text(8'h01, 1'b0, 1'b0, 32'd0);
      push_text(8'hFE, 1'b0, 1'b0, 32'd0);
      push_text(8'h20, 1'b0, 1'b0, 32'd0);
      push_text(8'h41, 1'b0, 1'b1, 32'd0);
      wait_idle();

      // Random phases, one of them with both sides streaming without pause
      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         queue_random_config(p);
         wait_idle();
         no_stall = (p == 3);
         queue_random_texts(PHASE_BYTES);
         wait_idle();
         no_stall = 1'b0;
      end

      $display("Sent %0d text bytes across %0d register writes;",
               bytes_sent, writes_done);
      $display("checked %0d results (%0d matches).", results_seen, matches_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("Timeout with %0d results still expected", pending_matches.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
